/* hw/rtl/taq_pkg.sv */
// Package for the transfer admission queue: command, result and
// configuration types, command and result codes, entry states, reset values.
// No dependencies.
`timescale 1ns / 1ps

package taq_pkg;

    localparam int DEF_SLOTS       = 32;
    localparam int DEF_CLIENT_BITS = 8;

    // Command codes as they arrive on the command word.
    localparam logic [2:0] CMD_ENQUEUE = 3'd0;
    localparam logic [2:0] CMD_START   = 3'd1;
    localparam logic [2:0] CMD_FINISH  = 3'd2;
    localparam logic [2:0] CMD_REMOVE  = 3'd3;
    localparam logic [2:0] CMD_TICK    = 3'd4;

    // Classified operations handed from the front to the back.
    localparam logic [2:0] OP_ENQUEUE = 3'd0;
    localparam logic [2:0] OP_START   = 3'd1;
    localparam logic [2:0] OP_FINISH  = 3'd2;
    localparam logic [2:0] OP_REMOVE  = 3'd3;
    localparam logic [2:0] OP_TICK    = 3'd4;
    localparam logic [2:0] OP_BAD     = 3'd5;

    localparam logic [1:0] KIND_OK    = 2'd0;
    localparam logic [1:0] KIND_FAIL  = 2'd1;
    localparam logic [1:0] KIND_MOVED = 2'd2;
    localparam logic [1:0] KIND_READY = 2'd3;

    localparam logic [1:0] ST_QUEUED   = 2'd0;
    localparam logic [1:0] ST_WAITING  = 2'd1;
    localparam logic [1:0] ST_RUNNING  = 2'd2;
    localparam logic [1:0] ST_STOPPING = 2'd3;

    localparam logic [2:0] REG_TOTAL_DL  = 3'd0;
    localparam logic [2:0] REG_TOTAL_UL  = 3'd1;
    localparam logic [2:0] REG_CLIENT_DL = 3'd2;
    localparam logic [2:0] REG_CLIENT_UL = 3'd3;
    localparam logic [2:0] REG_TIMEOUT   = 3'd4;

    localparam logic [7:0] RST_TOTAL_DL  = 8'd10;
    localparam logic [7:0] RST_TOTAL_UL  = 8'd10;
    localparam logic [7:0] RST_CLIENT_DL = 8'd1;
    localparam logic [7:0] RST_CLIENT_UL = 8'd1;
    localparam logic [7:0] RST_TIMEOUT   = 8'd20;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] client_id;
        logic       is_upload;
        logic [7:0] entry_tag;
    } taq_cmd_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  out_client;
        logic [7:0]  out_tag;
        logic [15:0] queue_position;
        logic        last;
    } taq_res_t;

    typedef struct packed {
        logic [7:0] total_download_limit;
        logic [7:0] total_upload_limit;
        logic [7:0] client_download_limit;
        logic [7:0] client_upload_limit;
        logic [7:0] waiting_timeout_ticks;
    } taq_cfg_t;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] client;
        logic       upload;
        logic [7:0] tag;
    } taq_op_t;

endpackage

/* hw/rtl/taq_front.sv */
// Command front end: accepts command words, classifies them and holds them
// in a two-word queue for the table engine. Depends on taq_pkg.
`timescale 1ns / 1ps

module taq_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  taq_pkg::taq_cmd_t command,
    output taq_pkg::taq_op_t  op,
    output logic              op_valid,
    input  logic              op_ready
);
    import taq_pkg::*;

    taq_op_t    q_reg [2];
    taq_op_t    in_op;
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;

    always_comb
    begin
        in_op.client = command.client_id;
        in_op.upload = command.is_upload;
        in_op.tag    = command.entry_tag;
        case (command.cmd)
            CMD_ENQUEUE: in_op.op = OP_ENQUEUE;
            CMD_START:   in_op.op = OP_START;
            CMD_FINISH:  in_op.op = OP_FINISH;
            CMD_REMOVE:  in_op.op = OP_REMOVE;
            CMD_TICK:    in_op.op = OP_TICK;
            default:     in_op.op = OP_BAD;
        endcase
    end

    assign busy     = (count_reg == 2'd2);
    assign op_valid = (count_reg != 2'd0);
    assign op       = q_reg[rd_ptr_reg];
    assign push     = start && !busy;
    assign pop      = op_valid && op_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= in_op;
        end
    end

endmodule

/* hw/rtl/taq_back.sv */
// Table engine: holds the ordered transfer table and executes one command at
// a time with walks over the table, emitting notices and a done word.
// Depends on taq_pkg.
`timescale 1ns / 1ps

module taq_back #(
    parameter int SLOTS       = taq_pkg::DEF_SLOTS,
    parameter int CLIENT_BITS = taq_pkg::DEF_CLIENT_BITS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  taq_pkg::taq_op_t  op,
    input  logic              op_valid,
    output logic              op_ready,
    input  taq_pkg::taq_cfg_t cfg,
    output logic              result_valid,
    output taq_pkg::taq_res_t result
);
    import taq_pkg::*;

    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_FIND = 3'd1;
    localparam logic [2:0] S_RMCL = 3'd2;
    localparam logic [2:0] S_TICK = 3'd3;
    localparam logic [2:0] S_CNT  = 3'd4;
    localparam logic [2:0] S_MIN  = 3'd5;
    localparam logic [2:0] S_POS  = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    typedef struct packed {
        logic [CLIENT_BITS-1:0] client;
        logic                   upload;
        logic [1:0]             status;
        logic [7:0]             id;
        logic [15:0]            pos;
        logic [7:0]             age;
    } ent_t;

    ent_t tbl_reg [SLOTS];

    logic [2:0]             state_reg, state_next;
    logic [CW-1:0]          idx_reg, idx_next;
    logic [CW-1:0]          fill_reg, fill_next;
    logic [7:0]             tag_reg, tag_next;
    taq_op_t                op_reg, op_next;
    logic                   changed_reg, changed_next;
    logic [CW-1:0]          all_d_reg, all_d_next, all_u_reg, all_u_next;
    logic [CW-1:0]          cd_reg, cd_next, cu_reg, cu_next;
    logic [CW-1:0]          pd_reg, pd_next, pu_reg, pu_next;
    logic [CLIENT_BITS-1:0] cur_c_reg, cur_c_next, prev_reg, prev_next;
    logic                   have_reg, have_next, prev_have_reg, prev_have_next;
    logic [7:0]             done_client_reg, done_client_next;
    logic [7:0]             done_tag_reg, done_tag_next;
    logic                   res_valid_reg;
    taq_res_t               res_reg;

    ent_t                   cur;
    logic                   in_range, cur_active;
    logic [CLIENT_BITS-1:0] in_client, op_client;
    logic [7:0]             age_inc;
    logic [CW-1:0]          p_cnt, all_sel, cc_sel;
    logic [7:0]             tl_sel, cl_sel;
    logic signed [CW:0]     diff;
    logic [15:0]            pos_val;

    logic                   wr_en, drop_en, emit_en;
    logic [IW-1:0]          wr_idx, drop_idx;
    ent_t                   wr_data;
    taq_res_t               emit_data;

    assign cur        = tbl_reg[idx_reg[IW-1:0]];
    assign in_range   = (idx_reg < fill_reg);
    assign cur_active = (cur.status == ST_WAITING) || (cur.status == ST_RUNNING);
    assign in_client  = CLIENT_BITS'(op.client);
    assign op_client  = CLIENT_BITS'(op_reg.client);
    assign age_inc    = (cur.age == 8'hFF) ? cur.age : cur.age + 8'd1;
    assign op_ready   = (state_reg == S_IDLE);

    // Position of the current queued entry against the active counts.
    always_comb
    begin
        p_cnt   = (cur.upload ? pu_reg : pd_reg) + CW'(1);
        all_sel = cur.upload ? all_u_reg : all_d_reg;
        cc_sel  = cur.upload ? cu_reg : cd_reg;
        tl_sel  = cur.upload ? cfg.total_upload_limit : cfg.total_download_limit;
        cl_sel  = cur.upload ? cfg.client_upload_limit : cfg.client_download_limit;
        if (16'(all_sel) >= 16'(tl_sel))
        begin
            diff = $signed({1'b0, p_cnt}) - $signed({1'b0, all_sel});
        end
        else if (16'(cc_sel) >= 16'(cl_sel))
        begin
            diff = $signed({1'b0, p_cnt}) - $signed({1'b0, cc_sel});
        end
        else
        begin
            diff = '0;
        end
        pos_val = diff[CW] ? 16'hFFFF : 16'(diff[CW-1:0]);
    end

    always_comb
    begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        fill_next        = fill_reg;
        tag_next         = tag_reg;
        op_next          = op_reg;
        changed_next     = changed_reg;
        all_d_next       = all_d_reg;
        all_u_next       = all_u_reg;
        cd_next          = cd_reg;
        cu_next          = cu_reg;
        pd_next          = pd_reg;
        pu_next          = pu_reg;
        cur_c_next       = cur_c_reg;
        prev_next        = prev_reg;
        have_next        = have_reg;
        prev_have_next   = prev_have_reg;
        done_client_next = done_client_reg;
        done_tag_next    = done_tag_reg;
        wr_en            = 1'b0;
        wr_idx           = idx_reg[IW-1:0];
        wr_data          = cur;
        drop_en          = 1'b0;
        drop_idx         = idx_reg[IW-1:0];
        emit_en          = 1'b0;
        emit_data        = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (op_valid)
                begin
                    op_next  = op;
                    idx_next = '0;
                    case (op.op)
                        OP_ENQUEUE:
                        begin
                            if (fill_reg == CW'(SLOTS))
                            begin
                                emit_en              = 1'b1;
                                emit_data.kind       = KIND_FAIL;
                                emit_data.out_client = 8'(in_client);
                                emit_data.last       = 1'b1;
                            end
                            else
                            begin
                                wr_en            = 1'b1;
                                wr_idx           = fill_reg[IW-1:0];
                                wr_data.client   = in_client;
                                wr_data.upload   = op.upload;
                                wr_data.status   = ST_QUEUED;
                                wr_data.id       = tag_reg;
                                wr_data.pos      = '0;
                                wr_data.age      = '0;
                                tag_next         = tag_reg + 8'd1;
                                fill_next        = fill_reg + CW'(1);
                                done_client_next = 8'(in_client);
                                done_tag_next    = tag_reg;
                                all_d_next       = '0;
                                all_u_next       = '0;
                                state_next       = S_CNT;
                            end
                        end
                        OP_START, OP_FINISH:
                        begin
                            state_next = S_FIND;
                        end
                        OP_REMOVE:
                        begin
                            changed_next     = 1'b0;
                            done_client_next = 8'(in_client);
                            done_tag_next    = '0;
                            state_next       = S_RMCL;
                        end
                        OP_TICK:
                        begin
                            changed_next     = 1'b0;
                            done_client_next = '0;
                            done_tag_next    = '0;
                            state_next       = S_TICK;
                        end
                        default:
                        begin
                            emit_en        = 1'b1;
                            emit_data.kind = KIND_FAIL;
                            emit_data.last = 1'b1;
                        end
                    endcase
                end
            end
            S_FIND:
            begin
                if (!in_range)
                begin
                    emit_en           = 1'b1;
                    emit_data.kind    = KIND_FAIL;
                    emit_data.out_tag = op_reg.tag;
                    emit_data.last    = 1'b1;
                    state_next        = S_IDLE;
                end
                else if (cur.id == op_reg.tag)
                begin
                    if (op_reg.op == OP_START)
                    begin
                        emit_en              = 1'b1;
                        emit_data.out_client = 8'(cur.client);
                        emit_data.out_tag    = op_reg.tag;
                        emit_data.last       = 1'b1;
                        if (cur.status != ST_WAITING)
                        begin
                            emit_data.kind = KIND_FAIL;
                        end
                        else
                        begin
                            emit_data.kind = KIND_OK;
                            wr_en          = 1'b1;
                            wr_data.status = ST_RUNNING;
                        end
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        drop_en          = 1'b1;
                        fill_next        = fill_reg - CW'(1);
                        done_client_next = 8'(cur.client);
                        done_tag_next    = op_reg.tag;
                        idx_next         = '0;
                        all_d_next       = '0;
                        all_u_next       = '0;
                        state_next       = S_CNT;
                    end
                end
                else
                begin
                    idx_next = idx_reg + CW'(1);
                end
            end
            S_RMCL:
            begin
                if (!in_range)
                begin
                    idx_next   = '0;
                    all_d_next = '0;
                    all_u_next = '0;
                    state_next = changed_reg ? S_CNT : S_DONE;
                end
                else if (cur.client == op_client && cur.status != ST_STOPPING)
                begin
                    if (cur.status == ST_RUNNING)
                    begin
                        wr_en          = 1'b1;
                        wr_data.status = ST_STOPPING;
                        idx_next       = idx_reg + CW'(1);
                    end
                    else
                    begin
                        // The next entry slides into this slot, so the index stays.
                        drop_en      = 1'b1;
                        fill_next    = fill_reg - CW'(1);
                        changed_next = 1'b1;
                    end
                end
                else
                begin
                    idx_next = idx_reg + CW'(1);
                end
            end
            S_TICK:
            begin
                if (!in_range)
                begin
                    idx_next   = '0;
                    all_d_next = '0;
                    all_u_next = '0;
                    state_next = changed_reg ? S_CNT : S_DONE;
                end
                else if (cur.status == ST_WAITING)
                begin
                    if (age_inc > cfg.waiting_timeout_ticks)
                    begin
                        drop_en      = 1'b1;
                        fill_next    = fill_reg - CW'(1);
                        changed_next = 1'b1;
                    end
                    else
                    begin
                        wr_en       = 1'b1;
                        wr_data.age = age_inc;
                        idx_next    = idx_reg + CW'(1);
                    end
                end
                else
                begin
                    idx_next = idx_reg + CW'(1);
                end
            end
            S_CNT:
            begin
                if (!in_range)
                begin
                    idx_next       = '0;
                    have_next      = 1'b0;
                    prev_have_next = 1'b0;
                    cd_next        = '0;
                    cu_next        = '0;
                    state_next     = S_MIN;
                end
                else
                begin
                    if (cur_active && cur.upload)
                    begin
                        all_u_next = all_u_reg + CW'(1);
                    end
                    if (cur_active && !cur.upload)
                    begin
                        all_d_next = all_d_reg + CW'(1);
                    end
                    idx_next = idx_reg + CW'(1);
                end
            end
            S_MIN:
            begin
                // Finds the next client in ascending order and counts its
                // active entries in the same walk.
                if (!in_range)
                begin
                    if (!have_reg)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        prev_next      = cur_c_reg;
                        prev_have_next = 1'b1;
                        idx_next       = '0;
                        pd_next        = '0;
                        pu_next        = '0;
                        state_next     = S_POS;
                    end
                end
                else
                begin
                    if (!prev_have_reg || cur.client > prev_reg)
                    begin
                        if (!have_reg || cur.client < cur_c_reg)
                        begin
                            cur_c_next = cur.client;
                            have_next  = 1'b1;
                            cd_next    = CW'(cur_active && !cur.upload);
                            cu_next    = CW'(cur_active && cur.upload);
                        end
                        else if (cur.client == cur_c_reg)
                        begin
                            cd_next = cd_reg + CW'(cur_active && !cur.upload);
                            cu_next = cu_reg + CW'(cur_active && cur.upload);
                        end
                    end
                    idx_next = idx_reg + CW'(1);
                end
            end
            S_POS:
            begin
                if (!in_range)
                begin
                    idx_next   = '0;
                    have_next  = 1'b0;
                    cd_next    = '0;
                    cu_next    = '0;
                    state_next = S_MIN;
                end
                else
                begin
                    if (cur.upload)
                    begin
                        pu_next = p_cnt;
                    end
                    else
                    begin
                        pd_next = p_cnt;
                    end
                    if (cur.status == ST_QUEUED && cur.client == cur_c_reg)
                    begin
                        emit_data.out_client = 8'(cur.client);
                        emit_data.out_tag    = cur.id;
                        if (pos_val != 16'd0)
                        begin
                            if (cur.pos != pos_val)
                            begin
                                wr_en                    = 1'b1;
                                wr_data.pos              = pos_val;
                                emit_en                  = 1'b1;
                                emit_data.kind           = KIND_MOVED;
                                emit_data.queue_position = pos_val;
                            end
                        end
                        else
                        begin
                            wr_en          = 1'b1;
                            wr_data.pos    = '0;
                            wr_data.status = ST_WAITING;
                            wr_data.age    = '0;
                            emit_en        = 1'b1;
                            emit_data.kind = KIND_READY;
                            if (cur.upload)
                            begin
                                all_u_next = all_u_reg + CW'(1);
                                cu_next    = cu_reg + CW'(1);
                            end
                            else
                            begin
                                all_d_next = all_d_reg + CW'(1);
                                cd_next    = cd_reg + CW'(1);
                            end
                        end
                    end
                    idx_next = idx_reg + CW'(1);
                end
            end
            S_DONE:
            begin
                emit_en              = 1'b1;
                emit_data.kind       = KIND_OK;
                emit_data.out_client = done_client_reg;
                emit_data.out_tag    = done_tag_reg;
                emit_data.last       = 1'b1;
                state_next           = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            idx_reg         <= '0;
            fill_reg        <= '0;
            tag_reg         <= '0;
            op_reg          <= '0;
            changed_reg     <= 1'b0;
            all_d_reg       <= '0;
            all_u_reg       <= '0;
            cd_reg          <= '0;
            cu_reg          <= '0;
            pd_reg          <= '0;
            pu_reg          <= '0;
            cur_c_reg       <= '0;
            prev_reg        <= '0;
            have_reg        <= 1'b0;
            prev_have_reg   <= 1'b0;
            done_client_reg <= '0;
            done_tag_reg    <= '0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            idx_reg         <= idx_next;
            fill_reg        <= fill_next;
            tag_reg         <= tag_next;
            op_reg          <= op_next;
            changed_reg     <= changed_next;
            all_d_reg       <= all_d_next;
            all_u_reg       <= all_u_next;
            cd_reg          <= cd_next;
            cu_reg          <= cu_next;
            pd_reg          <= pd_next;
            pu_reg          <= pu_next;
            cur_c_reg       <= cur_c_next;
            prev_reg        <= prev_next;
            have_reg        <= have_next;
            prev_have_reg   <= prev_have_next;
            done_client_reg <= done_client_next;
            done_tag_reg    <= done_tag_next;
            res_valid_reg   <= emit_en;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= emit_data;
    end

    // Valid entries always form a prefix of the table; a drop shifts every
    // later entry down by one slot.
    for (genvar g = 0; g < SLOTS; g++)
    begin : g_ent
        if (g < SLOTS - 1)
        begin : g_mid
            always_ff @(posedge clk)
            begin
                if (drop_en && drop_idx <= IW'(g))
                begin
                    tbl_reg[g] <= tbl_reg[g + 1];
                end
                else if (wr_en && wr_idx == IW'(g))
                begin
                    tbl_reg[g] <= wr_data;
                end
            end
        end
        else
        begin : g_last
            always_ff @(posedge clk)
            begin
                if (wr_en && !drop_en && wr_idx == IW'(g))
                begin
                    tbl_reg[g] <= wr_data;
                end
            end
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

`ifndef NO_ASSERTIONS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(SLOTS))
        else $error("table fill count beyond capacity");

    a_notice_from_pos: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !res_reg.last |-> $past(state_reg) == S_POS)
        else $error("notice word emitted outside the positioning walk");

    a_last_origin: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.last |->
            $past(state_reg) == S_IDLE || $past(state_reg) == S_FIND ||
            $past(state_reg) == S_DONE)
        else $error("closing word from an unexpected state");

    a_take_acts: assert property (@(posedge clk) disable iff (!rst_n)
        op_valid && state_reg == S_IDLE |=> state_reg != S_IDLE || res_valid_reg)
        else $error("accepted command neither started work nor closed");
`endif

endmodule

/* hw/rtl/transfer_admission_queue.sv */
// Transfer admission queue top level: configuration registers, command
// front end and table engine. Depends on taq_pkg, taq_front and taq_back.
// A start or a command with an unknown tag needs one walk over the table; an
// enqueue that repositions counts in one walk, then searches and positions
// client by client; finish, remove and tick add one more walk.
// Commands run one at a time in the table engine; two more are queued.
// Reset empties the table, clears the tag counter and loads default limits.
// Results are strobed for one cycle each and cannot be stalled.
`timescale 1ns / 1ps

module transfer_admission_queue #(
    parameter int SLOTS       = taq_pkg::DEF_SLOTS,
    parameter int CLIENT_BITS = taq_pkg::DEF_CLIENT_BITS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  taq_pkg::taq_cmd_t command,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [7:0]        cfg_data,
    output logic              result_valid,
    output taq_pkg::taq_res_t result
);
    import taq_pkg::*;

    taq_cfg_t cfg_reg, cfg_next;
    taq_op_t  op;
    logic     op_valid, op_ready;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_TOTAL_DL:  cfg_next.total_download_limit  = cfg_data;
                REG_TOTAL_UL:  cfg_next.total_upload_limit    = cfg_data;
                REG_CLIENT_DL: cfg_next.client_download_limit = cfg_data;
                REG_CLIENT_UL: cfg_next.client_upload_limit   = cfg_data;
                REG_TIMEOUT:   cfg_next.waiting_timeout_ticks = cfg_data;
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.total_download_limit  <= RST_TOTAL_DL;
            cfg_reg.total_upload_limit    <= RST_TOTAL_UL;
            cfg_reg.client_download_limit <= RST_CLIENT_DL;
            cfg_reg.client_upload_limit   <= RST_CLIENT_UL;
            cfg_reg.waiting_timeout_ticks <= RST_TIMEOUT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    taq_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .command  (command),
        .op       (op),
        .op_valid (op_valid),
        .op_ready (op_ready)
    );

    taq_back #(
        .SLOTS       (SLOTS),
        .CLIENT_BITS (CLIENT_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .op           (op),
        .op_valid     (op_valid),
        .op_ready     (op_ready),
        .cfg          (cfg_reg),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

/* tb/tb.sv */
// Self-checking testbench for transfer_admission_queue: a directed table, then
// random command phases under several limit settings, checked by a predictor.
// Depends on taq_pkg and the transfer_admission_queue RTL.
`timescale 1ns / 1ps

module tb;
    import taq_pkg::*;

    localparam int NSLOT      = 32;
    localparam int RAND_ITEMS = 350;
    localparam int PHASES     = 6;
    localparam int SETTLE     = 40;
    localparam longint CYCLE_LIMIT = 3000000;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    taq_cmd_t command;
    logic     cfg_valid;
    logic     cfg_ready;
    logic [2:0] cfg_index;
    logic [7:0] cfg_data;
    logic     result_valid;
    taq_res_t result;

    transfer_admission_queue dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .command(command),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .result_valid(result_valid), .result(result)
    );

    // Predictor copy of the table and limits.
    bit         tv [NSLOT];
    logic [7:0] tc [NSLOT];
    bit         tu [NSLOT];
    logic [1:0] ts [NSLOT];
    logic [7:0] tid [NSLOT];
    logic [15:0] tpos [NSLOT];
    logic [7:0] tage [NSLOT];
    logic [7:0] tag_ctr;
    logic [7:0] lim_tdl, lim_tul, lim_cdl, lim_cul, lim_tmo;

    taq_res_t pending_results[$];
    int errors = 0;
    int n_cmds = 0;
    int n_results = 0;
    int n_notices = 0;
    longint cycles = 0;
    bit quiet = 0;

    typedef struct {
        taq_cmd_t c;
        bit       typed;
        taq_res_t r;
    } row_t;

    function automatic taq_cmd_t mk_cmd(logic [2:0] op, logic [7:0] cl, logic up,
                                        logic [7:0] tg);
        taq_cmd_t c;
        c.cmd = op;
        c.client_id = cl;
        c.is_upload = up;
        c.entry_tag = tg;
        return c;
    endfunction

    function automatic taq_res_t mk_res(logic [1:0] k, logic [7:0] cl, logic [7:0] tg,
                                        logic [15:0] p, logic l);
        taq_res_t r;
        r.kind = k;
        r.out_client = cl;
        r.out_tag = tg;
        r.queue_position = p;
        r.last = l;
        return r;
    endfunction

    function automatic void drop_slot(int i);
        for (int j = i; j + 1 < NSLOT; j++) begin
            tv[j] = tv[j + 1];
            tc[j] = tc[j + 1];
            tu[j] = tu[j + 1];
            ts[j] = ts[j + 1];
            tid[j] = tid[j + 1];
            tpos[j] = tpos[j + 1];
            tage[j] = tage[j + 1];
        end
        tv[NSLOT - 1] = 0;
    endfunction

    function automatic int find_tag(logic [7:0] tg);
        for (int i = 0; i < NSLOT; i++)
            if (tv[i] && tid[i] == tg)
                return i;
        return -1;
    endfunction

    function automatic bit active(int i);
        return ts[i] == ST_WAITING || ts[i] == ST_RUNNING;
    endfunction

    // Recompute queue positions, client by client in ascending id order.
    function automatic void reposition();
        int all_d, all_u, prev, c, cd, cu, pd, pu, pos;
        logic [15:0] p;
        all_d = 0;
        all_u = 0;
        prev = -1;
        for (int i = 0; i < NSLOT; i++)
            if (tv[i] && active(i)) begin
                if (tu[i]) all_u++; else all_d++;
            end
        forever begin
            c = -1;
            cd = 0; cu = 0; pd = 0; pu = 0;
            for (int i = 0; i < NSLOT; i++)
                if (tv[i] && int'(tc[i]) > prev && (c < 0 || int'(tc[i]) < c))
                    c = int'(tc[i]);
            if (c < 0)
                break;
            prev = c;
            for (int i = 0; i < NSLOT; i++)
                if (tv[i] && int'(tc[i]) == c && active(i)) begin
                    if (tu[i]) cu++; else cd++;
                end
            for (int i = 0; i < NSLOT; i++) begin
                if (!tv[i])
                    continue;
                if (tu[i]) pu++; else pd++;
                if (ts[i] != ST_QUEUED || int'(tc[i]) != c)
                    continue;
                if (tu[i]) begin
                    if (all_u >= int'(lim_tul)) pos = pu - all_u;
                    else if (cu >= int'(lim_cul)) pos = pu - cu;
                    else pos = 0;
                end else begin
                    if (all_d >= int'(lim_tdl)) pos = pd - all_d;
                    else if (cd >= int'(lim_cdl)) pos = pd - cd;
                    else pos = 0;
                end
                p = (pos < 0 || pos > 65535) ? 16'hFFFF : pos[15:0];
                if (p != 0) begin
                    if (tpos[i] != p) begin
                        tpos[i] = p;
                        pending_results.push_back(mk_res(KIND_MOVED, tc[i], tid[i], p, 0));
                    end
                end else begin
                    tpos[i] = 0;
                    ts[i] = ST_WAITING;
                    tage[i] = 0;
                    pending_results.push_back(mk_res(KIND_READY, tc[i], tid[i], 0, 0));
                    if (tu[i]) begin all_u++; cu++; end
                    else begin all_d++; cd++; end
                end
            end
        end
    endfunction

    function automatic void predict_command(taq_cmd_t c);
        int slot, k, i;
        bit changed;
        logic [7:0] oc;
        slot = -1;
        changed = 0;
        case (c.cmd)
            CMD_ENQUEUE: begin
                for (i = 0; i < NSLOT; i++)
                    if (!tv[i]) begin slot = i; break; end
                if (slot < 0)
                    pending_results.push_back(mk_res(KIND_FAIL, c.client_id, 0, 0, 1));
                else begin
                    tv[slot] = 1;
                    tc[slot] = c.client_id;
                    tu[slot] = c.is_upload;
                    ts[slot] = ST_QUEUED;
                    tid[slot] = tag_ctr;
                    tpos[slot] = 0;
                    tage[slot] = 0;
                    oc = tag_ctr;
                    tag_ctr = tag_ctr + 8'd1;
                    reposition();
                    pending_results.push_back(mk_res(KIND_OK, c.client_id, oc, 0, 1));
                end
            end
            CMD_START: begin
                k = find_tag(c.entry_tag);
                if (k < 0)
                    pending_results.push_back(mk_res(KIND_FAIL, 0, c.entry_tag, 0, 1));
                else if (ts[k] != ST_WAITING)
                    pending_results.push_back(mk_res(KIND_FAIL, tc[k], c.entry_tag, 0, 1));
                else begin
                    ts[k] = ST_RUNNING;
                    pending_results.push_back(mk_res(KIND_OK, tc[k], c.entry_tag, 0, 1));
                end
            end
            CMD_FINISH: begin
                k = find_tag(c.entry_tag);
                if (k < 0)
                    pending_results.push_back(mk_res(KIND_FAIL, 0, c.entry_tag, 0, 1));
                else begin
                    oc = tc[k];
                    drop_slot(k);
                    reposition();
                    pending_results.push_back(mk_res(KIND_OK, oc, c.entry_tag, 0, 1));
                end
            end
            CMD_REMOVE: begin
                i = 0;
                while (i < NSLOT) begin
                    if (tv[i] && tc[i] == c.client_id && ts[i] != ST_STOPPING) begin
                        if (ts[i] == ST_RUNNING) begin
                            ts[i] = ST_STOPPING;
                            i++;
                        end else begin
                            drop_slot(i);
                            changed = 1;
                        end
                    end else
                        i++;
                end
                if (changed)
                    reposition();
                pending_results.push_back(mk_res(KIND_OK, c.client_id, 0, 0, 1));
            end
            CMD_TICK: begin
                i = 0;
                while (i < NSLOT) begin
                    if (tv[i] && ts[i] == ST_WAITING) begin
                        if (tage[i] < 8'd255)
                            tage[i]++;
                        if (tage[i] > lim_tmo) begin
                            drop_slot(i);
                            changed = 1;
                            continue;
                        end
                    end
                    i++;
                end
                if (changed)
                    reposition();
                pending_results.push_back(mk_res(KIND_OK, 0, 0, 0, 1));
            end
            default: pending_results.push_back(mk_res(KIND_FAIL, 0, 0, 0, 1));
        endcase
    endfunction

    initial begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Results cannot be held off, so every strobed word is checked on its edge.
    always @(posedge clk) begin
        taq_res_t want;
        if (rst_n && result_valid) begin
            n_results++;
            if (result.kind == KIND_MOVED || result.kind == KIND_READY)
                n_notices++;
            if (pending_results.size() == 0) begin
                $error("unexpected result word kind=%0d tag=%0d", result.kind, result.out_tag);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (result.kind != want.kind) begin
                    $error("kind: expected %0d, got %0d", want.kind, result.kind);
                    errors++;
                end
                if (result.out_client != want.out_client) begin
                    $error("out_client: expected %0d, got %0d", want.out_client,
                           result.out_client);
                    errors++;
                end
                if (result.out_tag != want.out_tag) begin
                    $error("out_tag: expected %0d, got %0d", want.out_tag, result.out_tag);
                    errors++;
                end
                if (result.queue_position != want.queue_position) begin
                    $error("queue_position: expected %0d, got %0d", want.queue_position,
                           result.queue_position);
                    errors++;
                end
                if (result.last != want.last) begin
                    $error("last: expected %0d, got %0d", want.last, result.last);
                    errors++;
                end
            end
        end
    end

    // Leaves start high; the caller lowers it only when it wants a gap.
    task automatic issue(taq_cmd_t c, bit typed, taq_res_t r);
        start <= 1'b1;
        command <= c;
        do @(posedge clk); while (busy);
        predict_command(c);
        if (typed) begin
            void'(pending_results.pop_back());
            pending_results.push_back(r);
        end
        n_cmds++;
    endtask

    task automatic maybe_idle();
        if (!quiet && $urandom_range(99) < 7) begin
            start <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Leaves valid high unless it inserts a random gap; the caller
    // lowers it after the last write.
    task automatic write_reg(logic [2:0] idx, logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_TOTAL_DL:  lim_tdl = val;
            REG_TOTAL_UL:  lim_tul = val;
            REG_CLIENT_DL: lim_cdl = val;
            REG_CLIENT_UL: lim_cul = val;
            default:       lim_tmo = val;
        endcase
        if ($urandom_range(99) < 7) begin
            cfg_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
    endtask

    function automatic taq_cmd_t random_command(int enq_weight);
        int r, k, n;
        logic [7:0] tg, cl;
        r = $urandom_range(99);
        cl = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(5));
        tg = 8'($urandom);
        n = 0;
        for (int i = 0; i < NSLOT; i++)
            if (tv[i]) n++;
        if (n > 0 && $urandom_range(9) < 8) begin
            k = $urandom_range(n - 1);
            tg = tid[k];
        end
        if (r < enq_weight)
            return mk_cmd(CMD_ENQUEUE, cl, 1'($urandom), 8'($urandom));
        r = $urandom_range(99);
        if (r < 35) return mk_cmd(CMD_START, 8'($urandom), 1'($urandom), tg);
        if (r < 60) return mk_cmd(CMD_FINISH, 8'($urandom), 1'($urandom), tg);
        if (r < 72) return mk_cmd(CMD_REMOVE, cl, 1'($urandom), 8'($urandom));
        if (r < 95) return mk_cmd(CMD_TICK, 8'($urandom), 1'($urandom), 8'($urandom));
        return mk_cmd(3'($urandom_range(7, 5)), 8'($urandom), 1'($urandom), 8'($urandom));
    endfunction

    initial begin
        row_t rows[$];
        taq_res_t none;
        int per_phase;
        none = mk_res(KIND_OK, 0, 0, 0, 0);
        rst_n = 1'b0;
        start = 1'b0;
        command = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        for (int i = 0; i < NSLOT; i++) tv[i] = 0;
        tag_ctr = 0;
        lim_tdl = RST_TOTAL_DL;
        lim_tul = RST_TOTAL_UL;
        lim_cdl = RST_CLIENT_DL;
        lim_cul = RST_CLIENT_UL;
        lim_tmo = RST_TIMEOUT;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed part, run with the reset limits.
        rows.push_back('{mk_cmd(CMD_START, 8'd9, 1'b0, 8'd5), 1,
                         mk_res(KIND_FAIL, 0, 8'd5, 0, 1)});
        rows.push_back('{mk_cmd(CMD_FINISH, 8'd0, 1'b1, 8'd200), 1,
                         mk_res(KIND_FAIL, 0, 8'd200, 0, 1)});
        rows.push_back('{mk_cmd(3'd5, 8'hFF, 1'b1, 8'hFF), 1, mk_res(KIND_FAIL, 0, 0, 0, 1)});
        rows.push_back('{mk_cmd(3'd7, 8'h00, 1'b0, 8'h00), 1, mk_res(KIND_FAIL, 0, 0, 0, 1)});
        rows.push_back('{mk_cmd(CMD_TICK, 8'd0, 1'b0, 8'd0), 1, mk_res(KIND_OK, 0, 0, 0, 1)});
        rows.push_back('{mk_cmd(CMD_ENQUEUE, 8'd0, 1'b0, 8'd0), 0, none});
        rows.push_back('{mk_cmd(CMD_ENQUEUE, 8'd0, 1'b0, 8'd0), 0, none});
        rows.push_back('{mk_cmd(CMD_ENQUEUE, 8'd255, 1'b1, 8'd0), 0, none});
        rows.push_back('{mk_cmd(CMD_ENQUEUE, 8'd255, 1'b1, 8'd0), 0, none});
        rows.push_back('{mk_cmd(CMD_ENQUEUE, 8'd128, 1'b0, 8'd0), 0, none});
        rows.push_back('{mk_cmd(CMD_ENQUEUE, 8'd0, 1'b1, 8'd0), 0, none});
        rows.push_back('{mk_cmd(CMD_START, 8'd0, 1'b0, 8'd0), 0, none});
        rows.push_back('{mk_cmd(CMD_START, 8'd0, 1'b0, 8'd0), 1,
                         mk_res(KIND_FAIL, 8'd0, 8'd0, 0, 1)});
        rows.push_back('{mk_cmd(CMD_START, 8'd0, 1'b0, 8'd1), 1,
                         mk_res(KIND_FAIL, 8'd0, 8'd1, 0, 1)});
        rows.push_back('{mk_cmd(CMD_REMOVE, 8'd0, 1'b0, 8'd0), 0, none});
        rows.push_back('{mk_cmd(CMD_REMOVE, 8'd0, 1'b0, 8'd0), 1,
                         mk_res(KIND_OK, 8'd0, 8'd0, 0, 1)});
        rows.push_back('{mk_cmd(CMD_FINISH, 8'd0, 1'b0, 8'd0), 0, none});
        rows.push_back('{mk_cmd(CMD_FINISH, 8'd0, 1'b0, 8'd3), 0, none});
        rows.push_back('{mk_cmd(CMD_START, 8'd0, 1'b0, 8'd2), 0, none});
        rows.push_back('{mk_cmd(CMD_TICK, 8'd0, 1'b0, 8'd0), 1, mk_res(KIND_OK, 0, 0, 0, 1)});
        rows.push_back('{mk_cmd(CMD_REMOVE, 8'd255, 1'b1, 8'd0), 0, none});
        rows.push_back('{mk_cmd(CMD_REMOVE, 8'd128, 1'b0, 8'd0), 0, none});
        foreach (rows[i]) begin
            issue(rows[i].c, rows[i].typed, rows[i].r);
            maybe_idle();
        end
        drain();

        // Random phases, each under its own limit setting.
        per_phase = RAND_ITEMS / PHASES;
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin
                    write_reg(REG_TOTAL_DL, 8'd0);   write_reg(REG_TOTAL_UL, 8'd0);
                    write_reg(REG_CLIENT_DL, 8'd0);  write_reg(REG_CLIENT_UL, 8'd0);
                    write_reg(REG_TIMEOUT, 8'd1);
                end
                1: begin
                    write_reg(REG_TOTAL_DL, 8'd255); write_reg(REG_TOTAL_UL, 8'd255);
                    write_reg(REG_CLIENT_DL, 8'd255); write_reg(REG_CLIENT_UL, 8'd255);
                    write_reg(REG_TIMEOUT, 8'd255);
                end
                default: begin
                    write_reg(REG_TOTAL_DL, 8'($urandom_range(6)));
                    write_reg(REG_TOTAL_UL, 8'($urandom_range(6)));
                    write_reg(REG_CLIENT_DL, 8'($urandom_range(3)));
                    write_reg(REG_CLIENT_UL, 8'($urandom_range(3)));
                    write_reg(REG_TIMEOUT, 8'($urandom_range(6, 1)));
                end
            endcase
            cfg_valid <= 1'b0;
            quiet = (ph == 2);
            for (int n = 0; n < per_phase; n++) begin
                // The full phase weights enqueues heavily so that the table tends to fill.
                issue(random_command(ph == 3 ? 85 : 40), 0, none);
                maybe_idle();
            end
            drain();
        end
        quiet = 0;

        $display("Ran %0d commands in %0d limit settings; %0d result words, %0d notices.",
                 n_cmds, PHASES + 1, n_results, n_notices);
        if (errors == 0 && pending_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

/* sim.f */
hw/rtl/taq_pkg.sv
hw/rtl/taq_front.sv
hw/rtl/taq_back.sv
hw/rtl/transfer_admission_queue.sv
tb/tb.sv
